// ===== design/bows_pkg.sv =====
`timescale 1ns / 1ps

package bows_pkg;

	// table size and bisection depth
	localparam int MAX_BOXES    = 128;
	localparam int IW           = $clog2(MAX_BOXES);
	localparam int CW           = $clog2(MAX_BOXES + 1);
	localparam int BISECT_STEPS = 12;
	localparam int KW           = $clog2(BISECT_STEPS + 1);

	// datapath widths, doubled Q7.8 for distances
	localparam int PW  = 18;   // box position during a move
	localparam int LW  = 17;   // clamp limit
	localparam int QW  = 19;   // per-axis distance term
	localparam int RW  = 19;   // square root result
	localparam int SQW = 2 * RW;
	localparam int DW  = 22;   // signed distance

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] REG_HALF_MAP_X     = 3'd0;
	localparam logic [CFG_IW-1:0] REG_HALF_MAP_Y     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_TICK_STEP      = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DRONE_RADIUS   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_REFLECT_MARGIN = 3'd4;
	localparam logic [CFG_IW-1:0] REG_REFLECT_ENABLE = 3'd5;
	localparam logic [CFG_IW-1:0] REG_ACTIVE_COUNT   = 3'd6;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TICK  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [6:0]         entry_index;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic [11:0]        half_width_x;
		logic [11:0]        half_width_y;
		logic signed [15:0] speed_x;
		logic signed [15:0] speed_y;
		logic               moves;
	} in_t;

	typedef struct packed {
		logic signed [15:0] clearance;
		logic               collision;
	} out_t;

	// datapath commands, decoded from the controller state
	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_ACCEPT,
		CMD_LOAD,
		CMD_READ,
		CMD_CAND_ENT,
		CMD_MV_X,
		CMD_MV_Y,
		CMD_CLX,
		CMD_CLY,
		CMD_DQ,
		CMD_SQX,
		CMD_SQY,
		CMD_SQZ,
		CMD_SQA,
		CMD_RT,
		CMD_DIST,
		CMD_QMIN,
		CMD_BV_X,
		CMD_BV_Y,
		CMD_BV_Z,
		CMD_BM_X,
		CMD_BM_Y,
		CMD_BM_C,
		CMD_BUPD,
		CMD_FM_X,
		CMD_FM_Y,
		CMD_FM_C,
		CMD_FCHK,
		CMD_WB,
		CMD_OUT
	} cmd_t;

	typedef struct packed {
		cmd_t          cmd;
		logic [IW-1:0] idx;
	} ctrl_t;

	typedef struct packed {
		logic [CW-1:0] n;
		logic          dyn;
		logic          refl;
		logic          close;
		logic          neg;
		logic          sq_done;
		logic          out_busy;
	} stat_t;

endpackage

// ===== design/bows_isqrt.sv =====
`timescale 1ns / 1ps

// floor square root, one result bit per cycle
module bows_isqrt import bows_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [SQW-1:0] radicand,
	output logic           done,
	output logic [RW-1:0]  root
);

	localparam int NW = $clog2(RW + 1);

	logic [SQW-1:0] rad_q;
	logic [RW+1:0]  rem_q;
	logic [RW-1:0]  root_q;
	logic [NW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [RW+3:0]  rem_t;
	logic [RW+3:0]  trial;
	logic           ge;

	// one digit step
	always_comb begin
		rem_t = {rem_q, rad_q[SQW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = (rem_t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= NW'(RW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQW-3:0], 2'b00};
			rem_q  <= ge ? (RW+2)'(rem_t - trial) : rem_t[RW+1:0];
			root_q <= {root_q[RW-2:0], ge};
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == NW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== design/bows_datapath.sv =====
`timescale 1ns / 1ps

// box table, shared multiplier, distance and move arithmetic
module bows_datapath import bows_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	output stat_t               stat,
	input  in_t                 in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_t                out_data,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data
);

	localparam int TRIAL_SH = 16 + BISECT_STEPS;
	localparam int FW       = BISECT_STEPS + 1;
	localparam int FXW      = BISECT_STEPS + 3;
	localparam int FRAC_ONE = 1 << BISECT_STEPS;
	localparam int MW       = 52;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [11:0]        hx;
		logic [11:0]        hy;
		logic signed [15:0] h;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
	} box_t;

	// configuration registers
	logic [14:0]        hmx_q, hmy_q, rad_q;
	logic [15:0]        dt_q;
	logic signed [15:0] margin_q;
	logic               refl_q;
	logic [7:0]         cnt_q;

	// working registers
	in_t                item_q;
	box_t               rd_q;
	box_t               mem [MAX_BOXES];
	logic               dyn_q [MAX_BOXES];
	logic signed [MW-1:0] prod_q;
	logic signed [31:0] vdtx_q, vdty_q;
	logic signed [LW-1:0] limx_q, limy_q;
	logic signed [PW-1:0] nx_q, ny_q, trx_q, candx_q, candy_q;
	logic signed [15:0] nvx_q, nvy_q;
	logic signed [QW-1:0] qx_q, qy_q, qz_q, inside_q;
	logic [SQW-1:0]     acc_q;
	logic signed [DW-1:0] dist_q, min_q;
	logic [FW-1:0]      safe_q, unsafe_q;
	out_t               out_q;
	logic               out_valid_q;

	logic               sq_done;
	logic [RW-1:0]      root;

	function automatic logic signed [PW-1:0] clamp_lim(input logic signed [PW-1:0] p,
		input logic signed [LW-1:0] lim);
		logic signed [PW-1:0] l;
		l = PW'(lim);
		if (p < -l)
			return -l;
		if (p > l)
			return l;
		return p;
	endfunction

	function automatic logic out_of(input logic signed [PW-1:0] p,
		input logic signed [LW-1:0] lim);
		logic signed [PW-1:0] l;
		l = PW'(lim);
		return (p < -l) || (p > l);
	endfunction

	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
		if (v == 16'sh8000)
			return 16'sh7fff;
		return -v;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmx_q    <= 15'd7680;
			hmy_q    <= 15'd7680;
			dt_q     <= 16'd1986;
			rad_q    <= 15'd77;
			margin_q <= 16'sd13;
			refl_q   <= 1'b0;
			cnt_q    <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_MAP_X:     hmx_q    <= cfg_data[14:0];
				REG_HALF_MAP_Y:     hmy_q    <= cfg_data[14:0];
				REG_TICK_STEP:      dt_q     <= cfg_data;
				REG_DRONE_RADIUS:   rad_q    <= cfg_data[14:0];
				REG_REFLECT_MARGIN: margin_q <= $signed(cfg_data);
				REG_REFLECT_ENABLE: refl_q   <= cfg_data[0];
				REG_ACTIVE_COUNT:   cnt_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// table write port
	logic          load_ok;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	box_t          mem_wd;

	always_comb begin
		load_ok = (32'(item_q.entry_index) < MAX_BOXES);
		mem_we  = 1'b0;
		mem_wa  = ctrl.idx;
		mem_wd  = rd_q;
		if (ctrl.cmd == CMD_LOAD) begin
			mem_we    = load_ok;
			mem_wa    = IW'(item_q.entry_index);
			mem_wd.cx = item_q.point_x;
			mem_wd.cy = item_q.point_y;
			mem_wd.h  = item_q.point_z;
			mem_wd.hx = item_q.half_width_x;
			mem_wd.hy = item_q.half_width_y;
			mem_wd.vx = item_q.speed_x;
			mem_wd.vy = item_q.speed_y;
		end else if (ctrl.cmd == CMD_WB) begin
			mem_we    = 1'b1;
			mem_wd.cx = nx_q[15:0];
			mem_wd.cy = ny_q[15:0];
			mem_wd.vx = nvx_q;
			mem_wd.vy = nvy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (ctrl.cmd == CMD_READ)
			rd_q <= mem[ctrl.idx];
	end

	// dynamic flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_BOXES; j++)
				dyn_q[j] <= 1'b0;
		end else if (ctrl.cmd == CMD_LOAD && load_ok) begin
			dyn_q[IW'(item_q.entry_index)] <= item_q.moves;
		end
	end

	// bisection fractions
	logic [FW-1:0]         mid;
	logic signed [FXW-1:0] f_wide;

	always_comb begin
		mid    = FW'((FW+1)'(safe_q) + (FW+1)'(unsafe_q) >> 1);
		f_wide = $signed({1'b0, safe_q, 1'b0}) - $signed(FXW'(FRAC_ONE));
	end

	// shared multiplier operands
	logic signed [32:0]   mul_a;
	logic signed [18:0]   mul_b;
	logic signed [QW-1:0] qpos;
	logic signed [18:0]   dt_s;

	always_comb begin
		dt_s  = $signed({3'b000, dt_q});
		qpos  = '0;
		mul_a = '0;
		mul_b = '0;
		case (ctrl.cmd)
			CMD_MV_X: begin
				mul_a = 33'(rd_q.vx);
				mul_b = dt_s;
			end
			CMD_MV_Y: begin
				mul_a = 33'(rd_q.vy);
				mul_b = dt_s;
			end
			CMD_BV_X: begin
				mul_a = 33'(nvx_q);
				mul_b = dt_s;
			end
			CMD_BV_Y: begin
				mul_a = 33'(nvy_q);
				mul_b = dt_s;
			end
			CMD_SQX: begin
				qpos  = (qx_q > 0) ? qx_q : '0;
				mul_a = 33'(qpos);
				mul_b = 19'(qpos);
			end
			CMD_SQY: begin
				qpos  = (qy_q > 0) ? qy_q : '0;
				mul_a = 33'(qpos);
				mul_b = 19'(qpos);
			end
			CMD_SQZ: begin
				qpos  = (qz_q > 0) ? qz_q : '0;
				mul_a = 33'(qpos);
				mul_b = 19'(qpos);
			end
			CMD_BM_X: begin
				mul_a = 33'(vdtx_q);
				mul_b = 19'($signed({1'b0, mid}));
			end
			CMD_BM_Y: begin
				mul_a = 33'(vdty_q);
				mul_b = 19'($signed({1'b0, mid}));
			end
			CMD_FM_X: begin
				mul_a = 33'(vdtx_q);
				mul_b = 19'(f_wide);
			end
			CMD_FM_Y: begin
				mul_a = 33'(vdty_q);
				mul_b = 19'(f_wide);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= MW'(mul_a) * MW'(mul_b);
	end

	// move, clamp and distance terms
	logic signed [PW-1:0] mvx, mvy, nx_raw, ny_raw, trial_x, trial_y;
	logic signed [LW-1:0] limx, limy;
	logic signed [19:0]   dx2, dy2, ax, ay;
	logic signed [18:0]   tz, az;
	logic signed [QW-1:0] qx, qy, qz, mx;

	always_comb begin
		limx    = $signed({2'b00, hmx_q}) - $signed({5'b00000, rd_q.hx});
		limy    = $signed({2'b00, hmy_q}) - $signed({5'b00000, rd_q.hy});
		mvx     = PW'(vdtx_q >>> 16);
		mvy     = PW'(vdty_q >>> 16);
		nx_raw  = PW'(rd_q.cx) + mvx;
		ny_raw  = PW'(rd_q.cy) + mvy;
		trial_x = PW'(rd_q.cx) + PW'(prod_q >>> TRIAL_SH);
		trial_y = PW'(rd_q.cy) + PW'(prod_q >>> TRIAL_SH);

		dx2 = (20'(item_q.point_x) - 20'(candx_q)) <<< 1;
		dy2 = (20'(item_q.point_y) - 20'(candy_q)) <<< 1;
		ax  = dx2[19] ? -dx2 : dx2;
		ay  = dy2[19] ? -dy2 : dy2;
		tz  = (19'(item_q.point_z) <<< 1) - 19'(rd_q.h);
		az  = tz[18] ? -tz : tz;
		qx  = QW'(ax - $signed({7'b0, rd_q.hx, 1'b0}));
		qy  = QW'(ay - $signed({7'b0, rd_q.hy, 1'b0}));
		qz  = QW'(az) - QW'(rd_q.h);
		mx  = qx;
		if (qy > mx)
			mx = qy;
		if (qz > mx)
			mx = qz;
	end

	// command execution
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_ACCEPT: begin
				item_q <= in_data;
				min_q  <= DW'(32767);
			end
			CMD_CAND_ENT: begin
				candx_q <= PW'(rd_q.cx);
				candy_q <= PW'(rd_q.cy);
			end
			CMD_MV_X: begin
				limx_q <= limx;
				limy_q <= limy;
			end
			CMD_MV_Y: vdtx_q <= prod_q[31:0];
			CMD_CLX: begin
				vdty_q <= prod_q[31:0];
				nx_q   <= out_of(nx_raw, limx_q) ? clamp_lim(nx_raw, limx_q) : nx_raw;
				nvx_q  <= out_of(nx_raw, limx_q) ? neg_sat(rd_q.vx) : rd_q.vx;
			end
			CMD_CLY: begin
				ny_q    <= out_of(ny_raw, limy_q) ? clamp_lim(ny_raw, limy_q) : ny_raw;
				nvy_q   <= out_of(ny_raw, limy_q) ? neg_sat(rd_q.vy) : rd_q.vy;
				candx_q <= nx_q;
				candy_q <= out_of(ny_raw, limy_q) ? clamp_lim(ny_raw, limy_q) : ny_raw;
			end
			CMD_DQ: begin
				qx_q     <= qx;
				qy_q     <= qy;
				qz_q     <= qz;
				inside_q <= (mx < 0) ? mx : '0;
			end
			CMD_SQY: acc_q <= prod_q[SQW-1:0];
			CMD_SQZ, CMD_SQA: acc_q <= acc_q + prod_q[SQW-1:0];
			CMD_DIST: begin
				dist_q <= $signed({3'b000, root}) + DW'(inside_q)
					- $signed({6'b000000, rad_q, 1'b0});
			end
			CMD_QMIN: begin
				if ((dist_q >>> 1) < min_q)
					min_q <= dist_q >>> 1;
			end
			CMD_BV_X: begin
				safe_q   <= '0;
				unsafe_q <= FW'(FRAC_ONE);
			end
			CMD_BV_Y: vdtx_q <= prod_q[31:0];
			CMD_BV_Z: vdty_q <= prod_q[31:0];
			CMD_BM_Y: trx_q <= trial_x;
			CMD_BM_C: begin
				candx_q <= trx_q;
				candy_q <= trial_y;
			end
			CMD_BUPD: begin
				if (stat.close)
					unsafe_q <= mid;
				else
					safe_q <= mid;
			end
			CMD_FM_Y: trx_q <= clamp_lim(trial_x, limx_q);
			CMD_FM_C: begin
				candx_q <= trx_q;
				candy_q <= clamp_lim(trial_y, limy_q);
				nvx_q   <= neg_sat(nvx_q);
				nvy_q   <= neg_sat(nvy_q);
			end
			CMD_FCHK: begin
				nx_q <= stat.neg ? PW'(rd_q.cx) : candx_q;
				ny_q <= stat.neg ? PW'(rd_q.cy) : candy_q;
			end
			CMD_OUT: begin
				out_q.clearance <= (min_q < DW'(-32768)) ? 16'sh8000 : min_q[15:0];
				out_q.collision <= (min_q <= 0);
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.cmd == CMD_OUT)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	bows_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.cmd == CMD_RT),
		.radicand (acc_q),
		.done     (sq_done),
		.root     (root)
	);

	// status to the controller
	always_comb begin
		stat.n        = (cnt_q > 8'(MAX_BOXES)) ? CW'(MAX_BOXES) : CW'(cnt_q);
		stat.dyn      = dyn_q[ctrl.idx];
		stat.refl     = refl_q;
		stat.close    = dist_q < (DW'(margin_q) <<< 1);
		stat.neg      = dist_q[DW-1];
		stat.sq_done  = sq_done;
		stat.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/bows_ctrl.sv =====
`timescale 1ns / 1ps

// sequencer: walks the table and steps the datapath
module bows_ctrl import bows_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  stat_t      stat,
	output ctrl_t      ctrl
);

	typedef enum logic [5:0] {
		S_IDLE, S_LOAD,
		S_TSEL, S_TRD, S_MVX, S_MVY, S_CLX, S_CLY,
		S_DQ, S_SQX, S_SQY, S_SQZ, S_SQA, S_RT, S_RTW, S_DIST, S_DRET,
		S_QSEL, S_QRD, S_QENT, S_QMIN, S_QOUT,
		S_BVX, S_BVY, S_BVZ, S_BMX, S_BMY, S_BMC, S_BUPD,
		S_FMX, S_FMY, S_FMC, S_FCHK, S_WB
	} state_t;

	typedef enum logic [1:0] {
		PH_QUERY, PH_CHECK, PH_BISECT, PH_FINAL
	} phase_t;

	state_t        state_q;
	phase_t        ph_q;
	logic [CW-1:0] i_q;
	logic [KW-1:0] k_q;

	// command decode
	always_comb begin
		ctrl.idx = i_q[IW-1:0];
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE:  ctrl.cmd = in_valid ? CMD_ACCEPT : CMD_NOP;
			S_LOAD:  ctrl.cmd = CMD_LOAD;
			S_TRD:   ctrl.cmd = CMD_READ;
			S_QRD:   ctrl.cmd = CMD_READ;
			S_QENT:  ctrl.cmd = CMD_CAND_ENT;
			S_MVX:   ctrl.cmd = CMD_MV_X;
			S_MVY:   ctrl.cmd = CMD_MV_Y;
			S_CLX:   ctrl.cmd = CMD_CLX;
			S_CLY:   ctrl.cmd = CMD_CLY;
			S_DQ:    ctrl.cmd = CMD_DQ;
			S_SQX:   ctrl.cmd = CMD_SQX;
			S_SQY:   ctrl.cmd = CMD_SQY;
			S_SQZ:   ctrl.cmd = CMD_SQZ;
			S_SQA:   ctrl.cmd = CMD_SQA;
			S_RT:    ctrl.cmd = CMD_RT;
			S_DIST:  ctrl.cmd = CMD_DIST;
			S_QMIN:  ctrl.cmd = CMD_QMIN;
			S_QOUT:  ctrl.cmd = stat.out_busy ? CMD_NOP : CMD_OUT;
			S_BVX:   ctrl.cmd = CMD_BV_X;
			S_BVY:   ctrl.cmd = CMD_BV_Y;
			S_BVZ:   ctrl.cmd = CMD_BV_Z;
			S_BMX:   ctrl.cmd = CMD_BM_X;
			S_BMY:   ctrl.cmd = CMD_BM_Y;
			S_BMC:   ctrl.cmd = CMD_BM_C;
			S_BUPD:  ctrl.cmd = CMD_BUPD;
			S_FMX:   ctrl.cmd = CMD_FM_X;
			S_FMY:   ctrl.cmd = CMD_FM_Y;
			S_FMC:   ctrl.cmd = CMD_FM_C;
			S_FCHK:  ctrl.cmd = CMD_FCHK;
			S_WB:    ctrl.cmd = CMD_WB;
			default: ctrl.cmd = CMD_NOP;
		endcase
	end

	// state, box index, bisection step and return phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_QUERY;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						i_q <= '0;
						case (opcode)
							OP_LOAD:  state_q <= S_LOAD;
							OP_TICK:  state_q <= S_TSEL;
							OP_QUERY: state_q <= S_QSEL;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				// tick walk over dynamic boxes
				S_TSEL: begin
					if (i_q == stat.n)
						state_q <= S_IDLE;
					else if (stat.dyn)
						state_q <= S_TRD;
					else
						i_q <= i_q + 1'b1;
				end
				S_TRD: state_q <= S_MVX;
				S_MVX: state_q <= S_MVY;
				S_MVY: state_q <= S_CLX;
				S_CLX: state_q <= S_CLY;
				S_CLY: begin
					if (stat.refl) begin
						ph_q    <= PH_CHECK;
						state_q <= S_DQ;
					end else begin
						state_q <= S_WB;
					end
				end
				// distance sequence
				S_DQ:  state_q <= S_SQX;
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SQZ;
				S_SQZ: state_q <= S_SQA;
				S_SQA: state_q <= S_RT;
				S_RT:  state_q <= S_RTW;
				S_RTW: begin
					if (stat.sq_done)
						state_q <= S_DIST;
				end
				S_DIST: state_q <= S_DRET;
				S_DRET: begin
					case (ph_q)
						PH_QUERY:  state_q <= S_QMIN;
						PH_CHECK:  state_q <= stat.close ? S_BVX : S_WB;
						PH_BISECT: state_q <= S_BUPD;
						PH_FINAL:  state_q <= S_FCHK;
						default:   state_q <= S_IDLE;
					endcase
				end
				// query walk
				S_QSEL: state_q <= (i_q == stat.n) ? S_QOUT : S_QRD;
				S_QRD:  state_q <= S_QENT;
				S_QENT: begin
					ph_q    <= PH_QUERY;
					state_q <= S_DQ;
				end
				S_QMIN: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_QSEL;
				end
				S_QOUT: begin
					if (!stat.out_busy)
						state_q <= S_IDLE;
				end
				// contact search
				S_BVX: state_q <= S_BVY;
				S_BVY: state_q <= S_BVZ;
				S_BVZ: begin
					k_q     <= '0;
					state_q <= S_BMX;
				end
				S_BMX: state_q <= S_BMY;
				S_BMY: state_q <= S_BMC;
				S_BMC: begin
					ph_q    <= PH_BISECT;
					state_q <= S_DQ;
				end
				S_BUPD: begin
					if (k_q == KW'(BISECT_STEPS - 1)) begin
						state_q <= S_FMX;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_BMX;
					end
				end
				// bounce back and penetration check
				S_FMX: state_q <= S_FMY;
				S_FMY: state_q <= S_FMC;
				S_FMC: begin
					ph_q    <= PH_FINAL;
					state_q <= S_DQ;
				end
				S_FCHK: state_q <= S_WB;
				S_WB: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_TSEL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/box_obstacle_world_step.sv =====
`timescale 1ns / 1ps

// Load writes one table entry. Query measures the distance to each of the n boxes in
// use and keeps the minimum, result held in an output register. Tick moves each dynamic
// box; with the bounce check on, a box that comes too close bisects for contact and is checked again.
// Each distance costs a shared 33x19 multiplier for three squares and a 19-step
// bit-serial square root. Items are taken one at a time. Reset restores the register
// defaults and clears the dynamic flags; table contents are undefined until loaded.
module box_obstacle_world_step import bows_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	ctrl_t ctrl;
	stat_t stat;

	bows_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (in_data.opcode),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	bows_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
